// ===== rtl/homogeneous_point_transform_macros.svh =====
// Assertion macros for the homogeneous point transform.
// Depends on clk and rst_n being visible in the module that uses them.
`ifndef HOMOGENEOUS_POINT_TRANSFORM_MACROS_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define HPT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hpt assertion failed");

// Check that cons holds in the cycle after ante.
`define HPT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hpt assertion failed");

`endif

// ===== rtl/hpt_pkg.sv =====
// Shared types and constants for the homogeneous point transform.
// No dependencies.
`default_nettype none

package hpt_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int CW         = 32;
    localparam int PW         = 2 * CW;
    localparam int SUMW       = PW + 2;
    localparam int HW         = SUMW - FRAC_BITS;
    localparam int NW         = HW + FRAC_BITS;
    localparam int QW         = 32;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = QW / DIV_STEP;
    localparam int NUM_ROWS   = 4;
    localparam int NUM_LANES  = 3;
    localparam int NUM_REGS   = 8;
    localparam int REG_IDX_W  = $clog2(NUM_REGS);
    localparam int CFG_IDX_W  = REG_IDX_W + 1;
    localparam int NST        = DIV_STAGES + 4;

    localparam logic [CW-1:0] RES_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] RES_MIN = {1'b1, {(CW-1){1'b0}}};

    localparam logic [PW-1:0] ONE_LO = PW'(1) << FRAC_BITS;
    localparam logic [PW-1:0] ONE_HI = PW'(1) << (FRAC_BITS + CW);

    localparam logic [PW-1:0] CFG_RESET [NUM_REGS] = '{
        ONE_LO, '0, ONE_HI, '0, '0, ONE_LO, '0, ONE_HI
    };

    typedef struct packed {
        logic signed [CW-1:0] point_x;
        logic signed [CW-1:0] point_y;
        logic signed [CW-1:0] point_z;
    } in_word_t;

    typedef struct packed {
        logic signed [CW-1:0] result_x;
        logic signed [CW-1:0] result_y;
        logic signed [CW-1:0] result_z;
        logic signed [CW-1:0] result_w;
        logic                 w_is_zero;
        logic                 saturated;
    } out_word_t;

    typedef struct packed {
        logic [HW-1:0] rem;
        logic [HW-1:0] den;
        logic [QW-1:0] quo;
        logic [QW-1:0] num_lo;
        logic          neg;
        logic          ovf;
    } div_lane_t;

    typedef struct packed {
        logic          w_zero;
        logic          w_sat;
        logic [CW-1:0] w_res;
    } meta_t;

endpackage

`default_nettype wire

// ===== rtl/hpt_div_stage.sv =====
// One slice of the restoring divider: DIV_STEP quotient bits per stage.
// Depends on hpt_pkg.
`default_nettype none

module hpt_div_stage (
    input  wire hpt_pkg::div_lane_t lane_in,
    output hpt_pkg::div_lane_t      lane_out
);

    always_comb
    begin
        hpt_pkg::div_lane_t l;
        logic [hpt_pkg::HW:0] trial;
        l = lane_in;
        for (int i = 0; i < hpt_pkg::DIV_STEP; i++)
        begin
            trial = {l.rem, l.num_lo[hpt_pkg::QW-1]};
            l.num_lo = l.num_lo << 1;
            if (trial >= {1'b0, l.den})
            begin
                trial = trial - {1'b0, l.den};
                l.quo = {l.quo[hpt_pkg::QW-2:0], 1'b1};
            end
            else
            begin
                l.quo = {l.quo[hpt_pkg::QW-2:0], 1'b0};
            end
            l.rem = trial[hpt_pkg::HW-1:0];
        end
        lane_out = l;
    end

endmodule

`default_nettype wire

// ===== rtl/homogeneous_point_transform.sv =====
// Top level of the homogeneous point transform: matrix registers, pipeline.
// Depends on hpt_pkg, hpt_div_stage and the assertion macro header.
//
// Usage:
//   in channel  (in_valid/in_ready/in_data): one point word, signed Q16.16.
//   out channel (out_valid/out_ready/out_data): transformed point, w, flags.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): matrix registers,
//     always ready; an index beyond the eight registers is dropped.
//   Throughput: one word per cycle unless stalled; stages are a multiplier
//     bank, a row adder, a divider setup, eight 4-bit divider slices and an
//     output register. Every stage has its own valid bit and fills bubbles.
//   Reset: all stages empty, matrix set to identity.
//   Receiver stall: words hold in place; in_ready drops only once every
//     stage is full.
`default_nettype none
`include "homogeneous_point_transform_macros.svh"

module homogeneous_point_transform (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    output logic                               in_ready,
    input  wire hpt_pkg::in_word_t             in_data,
    output logic                               out_valid,
    input  wire                                out_ready,
    output hpt_pkg::out_word_t                 out_data,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire [hpt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire [hpt_pkg::PW-1:0]              cfg_data
);

    localparam int NST = hpt_pkg::NST;
    localparam int DS  = hpt_pkg::DIV_STAGES;
    localparam int HW  = hpt_pkg::HW;
    localparam int CW  = hpt_pkg::CW;
    localparam int QW  = hpt_pkg::QW;
    localparam int FB  = hpt_pkg::FRAC_BITS;
    localparam logic [QW-1:0] Q_HALF = QW'(1) << (QW - 1);

    logic [hpt_pkg::PW-1:0]   coef_reg [hpt_pkg::NUM_REGS];
    logic [NST-1:0]           valid_reg;
    logic [NST-1:0]           adv;

    logic signed [hpt_pkg::PW-1:0] prod_reg  [hpt_pkg::NUM_ROWS][hpt_pkg::NUM_LANES];
    logic signed [hpt_pkg::PW-1:0] prod_next [hpt_pkg::NUM_ROWS][hpt_pkg::NUM_LANES];
    logic [HW-1:0]                 h_reg  [hpt_pkg::NUM_ROWS];
    logic [HW-1:0]                 h_next [hpt_pkg::NUM_ROWS];
    hpt_pkg::div_lane_t            lane_reg  [DS+1][hpt_pkg::NUM_LANES];
    hpt_pkg::div_lane_t            lane_next [DS+1][hpt_pkg::NUM_LANES];
    hpt_pkg::meta_t                meta_reg [DS+1];
    hpt_pkg::meta_t                meta_next;
    hpt_pkg::out_word_t            out_reg;
    hpt_pkg::out_word_t            out_next;
    logic signed [CW-1:0]          pt [hpt_pkg::NUM_LANES];

    assign cfg_ready = 1'b1;
    assign in_ready  = adv[0];
    assign out_valid = valid_reg[NST-1];
    assign out_data  = out_reg;

    assign pt[0] = in_data.point_x;
    assign pt[1] = in_data.point_y;
    assign pt[2] = in_data.point_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < hpt_pkg::NUM_REGS; i++)
            begin
                coef_reg[i] <= hpt_pkg::CFG_RESET[i];
            end
        end
        else if (cfg_valid && (cfg_index < hpt_pkg::CFG_IDX_W'(hpt_pkg::NUM_REGS)))
        begin
            coef_reg[cfg_index[hpt_pkg::REG_IDX_W-1:0]] <= cfg_data;
        end
    end

    always_comb
    begin
        adv[NST-1] = !valid_reg[NST-1] || out_ready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // multiplier bank
    always_comb
    begin
        for (int r = 0; r < hpt_pkg::NUM_ROWS; r++)
        begin
            for (int c = 0; c < hpt_pkg::NUM_LANES; c++)
            begin
                prod_next[r][c] = $signed(coef_reg[hpt_pkg::REG_IDX_W'(2 * r + (c >> 1))]
                                          [CW * (c & 1) +: CW]) * pt[c];
            end
        end
    end

    // row sums, floor shift by the fraction width
    always_comb
    begin
        logic [hpt_pkg::SUMW-1:0] sum;
        logic [CW-1:0]            c3;
        for (int r = 0; r < hpt_pkg::NUM_ROWS; r++)
        begin
            c3  = coef_reg[hpt_pkg::REG_IDX_W'(2 * r + 1)][2*CW-1:CW];
            sum = {{2{prod_reg[r][0][hpt_pkg::PW-1]}}, prod_reg[r][0]}
                + {{2{prod_reg[r][1][hpt_pkg::PW-1]}}, prod_reg[r][1]}
                + {{2{prod_reg[r][2][hpt_pkg::PW-1]}}, prod_reg[r][2]}
                + {{(hpt_pkg::SUMW-CW-FB){c3[CW-1]}}, c3, {FB{1'b0}}};
            h_next[r] = sum[hpt_pkg::SUMW-1:FB];
        end
    end

    // divider setup and w clipping
    always_comb
    begin
        logic [HW-1:0]          hw;
        logic [HW-1:0]          den;
        logic [HW-1:0]          mag;
        logic [hpt_pkg::NW-1:0] num;
        logic                   w_fits;
        hw     = h_reg[3];
        den    = hw[HW-1] ? (HW'(0) - hw) : hw;
        w_fits = (&hw[HW-1:CW-1]) || !(|hw[HW-1:CW-1]);
        meta_next.w_zero = (hw == '0);
        meta_next.w_sat  = !w_fits;
        meta_next.w_res  = w_fits ? hw[CW-1:0]
                                  : (hw[HW-1] ? hpt_pkg::RES_MIN : hpt_pkg::RES_MAX);
        for (int l = 0; l < hpt_pkg::NUM_LANES; l++)
        begin
            mag = h_reg[l][HW-1] ? (HW'(0) - h_reg[l]) : h_reg[l];
            num = {mag, {FB{1'b0}}};
            lane_next[0][l].den    = den;
            lane_next[0][l].rem    = HW'(num[hpt_pkg::NW-1:QW]);
            lane_next[0][l].ovf    = HW'(num[hpt_pkg::NW-1:QW]) >= den;
            lane_next[0][l].num_lo = num[QW-1:0];
            lane_next[0][l].quo    = '0;
            lane_next[0][l].neg    = h_reg[l][HW-1] ^ hw[HW-1];
        end
    end

    for (genvar s = 0; s < DS; s++)
    begin : g_div
        for (genvar l = 0; l < hpt_pkg::NUM_LANES; l++)
        begin : g_lane
            hpt_div_stage u_div (
                .lane_in  (lane_reg[s][l]),
                .lane_out (lane_next[s+1][l])
            );
        end
    end

    // sign, clip and zero-w handling
    always_comb
    begin
        logic [CW-1:0]                res [hpt_pkg::NUM_LANES];
        logic [hpt_pkg::NUM_LANES-1:0] sat;
        hpt_pkg::div_lane_t           q;
        for (int l = 0; l < hpt_pkg::NUM_LANES; l++)
        begin
            q = lane_reg[DS][l];
            if (q.ovf)
            begin
                res[l] = q.neg ? hpt_pkg::RES_MIN : hpt_pkg::RES_MAX;
                sat[l] = 1'b1;
            end
            else if (!q.neg)
            begin
                res[l] = q.quo[QW-1] ? hpt_pkg::RES_MAX : q.quo;
                sat[l] = q.quo[QW-1];
            end
            else
            begin
                res[l] = (q.quo > Q_HALF) ? hpt_pkg::RES_MIN : (QW'(0) - q.quo);
                sat[l] = q.quo > Q_HALF;
            end
        end
        if (meta_reg[DS].w_zero)
        begin
            out_next = '0;
            out_next.w_is_zero = 1'b1;
        end
        else
        begin
            out_next.result_x  = res[0];
            out_next.result_y  = res[1];
            out_next.result_z  = res[2];
            out_next.result_w  = meta_reg[DS].w_res;
            out_next.w_is_zero = 1'b0;
            out_next.saturated = (|sat) || meta_reg[DS].w_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            prod_reg <= prod_next;
        end
        if (adv[1])
        begin
            h_reg <= h_next;
        end
        if (adv[2])
        begin
            lane_reg[0] <= lane_next[0];
            meta_reg[0] <= meta_next;
        end
        for (int s = 1; s <= DS; s++)
        begin
            if (adv[s+2])
            begin
                lane_reg[s] <= lane_next[s];
                meta_reg[s] <= meta_reg[s-1];
            end
        end
        if (adv[NST-1])
        begin
            out_reg <= out_next;
        end
    end

    `HPT_ASSERT_IMP(a_full_stall, !in_ready, out_valid && !out_ready)
    `HPT_ASSERT_IMP(a_wzero_clear, out_valid && out_data.w_is_zero,
        out_data.result_x == '0 && out_data.result_y == '0 &&
        out_data.result_z == '0 && out_data.result_w == '0 && !out_data.saturated)
    `HPT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
    `HPT_ASSERT_IMP(a_cfg_ready, 1'b1, cfg_ready)

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for homogeneous_point_transform: random matrices and points, scoreboard check.
// Depends on hpt_pkg and the homogeneous_point_transform RTL.
`timescale 1ns / 100ps

module tb;

    localparam int REG_R0C01 = 0;
    localparam int REG_R0C23 = 1;
    localparam int REG_R1C01 = 2;
    localparam int REG_R1C23 = 3;
    localparam int REG_R2C01 = 4;
    localparam int REG_R2C23 = 5;
    localparam int REG_R3C01 = 6;
    localparam int REG_R3C23 = 7;
    localparam int LATENCY = 12;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ITEMS_PER_SETTING = 97;
    localparam int SETTINGS_PER_PHASE = 6;
    localparam logic [31:0] Q_ONE = 32'h0001_0000;
    localparam logic [31:0] Q_NEG_ONE = 32'hffff_0000;
    localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    class point_scoreboard;
        logic [hpt_pkg::PW-1:0] coef_regs [hpt_pkg::NUM_REGS];
        hpt_pkg::out_word_t expected_words [$];
        int mismatches;

        function new();
            for (int i = 0; i < hpt_pkg::NUM_REGS; i++)
                coef_regs[i] = hpt_pkg::CFG_RESET[i];
            mismatches = 0;
        endfunction

        function void set_reg(int idx, logic [hpt_pkg::PW-1:0] val);
            coef_regs[idx] = val;
        endfunction

        function logic signed [79:0] clip(logic signed [79:0] v, inout logic sat);
            logic signed [79:0] hi, lo;
            hi = 80'sd2147483647;
            lo = -80'sd2147483648;
            if (v > hi)
            begin
                sat = 1'b1;
                return hi;
            end
            if (v < lo)
            begin
                sat = 1'b1;
                return lo;
            end
            return v;
        endfunction

        function hpt_pkg::out_word_t project(hpt_pkg::in_word_t w);
            logic signed [79:0] p [4];
            logic signed [79:0] h [4];
            logic signed [79:0] res [3];
            logic signed [79:0] acc, cv, mag, v;
            logic signed [31:0] cf;
            logic [127:0] un, ud, q;
            logic sat;
            hpt_pkg::out_word_t o;
            p[0] = w.point_x;
            p[1] = w.point_y;
            p[2] = w.point_z;
            p[3] = 80'sd65536;
            sat = 1'b0;
            for (int r = 0; r < 4; r++)
            begin
                acc = '0;
                for (int c = 0; c < 4; c++)
                begin
                    cf = coef_regs[r * 2 + c / 2][(c % 2) * 32 +: 32];
                    cv = cf;
                    acc = acc + cv * p[c];
                end
                h[r] = acc >>> hpt_pkg::FRAC_BITS;
            end
            o = '0;
            if (h[3] == 0)
            begin
                o.w_is_zero = 1'b1;
                return o;
            end
            mag = (h[3] < 0) ? -h[3] : h[3];
            ud = 128'(mag);
            for (int i = 0; i < 3; i++)
            begin
                mag = (h[i] < 0) ? -h[i] : h[i];
                un = 128'(mag);
                q = (un << hpt_pkg::FRAC_BITS) / ud;
                if (q > (128'd1 << 40))
                    q = 128'd1 << 40;
                v = 80'(q[40:0]);
                if ((h[i] < 0) != (h[3] < 0))
                    v = -v;
                res[i] = clip(v, sat);
            end
            v = clip(h[3], sat);
            o.result_x = res[0][31:0];
            o.result_y = res[1][31:0];
            o.result_z = res[2][31:0];
            o.result_w = v[31:0];
            o.saturated = sat;
            return o;
        endfunction

        function void note_point(hpt_pkg::in_word_t w);
            expected_words.push_back(project(w));
        endfunction

        task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
            mismatches++;
        endtask

        task check_word(hpt_pkg::out_word_t got);
            hpt_pkg::out_word_t want;
            if (expected_words.size() == 0)
            begin
                $display("unexpected output word %h at %0t", got, $realtime);
                mismatches++;
                return;
            end
            want = expected_words.pop_front();
            if (got.result_x !== want.result_x)
                report_mismatch("result_x", got.result_x, want.result_x);
            if (got.result_y !== want.result_y)
                report_mismatch("result_y", got.result_y, want.result_y);
            if (got.result_z !== want.result_z)
                report_mismatch("result_z", got.result_z, want.result_z);
            if (got.result_w !== want.result_w)
                report_mismatch("result_w", got.result_w, want.result_w);
            if (got.w_is_zero !== want.w_is_zero)
                report_mismatch("w_is_zero", got.w_is_zero, want.w_is_zero);
            if (got.saturated !== want.saturated)
                report_mismatch("saturated", got.saturated, want.saturated);
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    hpt_pkg::in_word_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    hpt_pkg::out_word_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [hpt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [hpt_pkg::PW-1:0] cfg_data = '0;

    int send_idle_pct = 7;
    int recv_stall_pct = 82;
    int quiet_cycles = 0;
    point_scoreboard sb = new();

    homogeneous_point_transform uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            sb.note_point(in_data);
        if (out_valid && out_ready)
            sb.check_word(out_data);
        if (cfg_valid && cfg_ready && cfg_index < hpt_pkg::NUM_REGS)
            sb.set_reg(cfg_index, cfg_data);
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("homogeneous_point_transform regression: fail");
            $finish;
        end
    end

    task cfg_write(int idx, logic [hpt_pkg::PW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx[hpt_pkg::CFG_IDX_W-1:0];
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task cfg_release();
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        hpt_pkg::in_word_t w;
        w.point_x = x;
        w.point_y = y;
        w.point_z = z;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task drain();
        in_valid <= 1'b0;
        while (sb.expected_words.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task load_matrix(logic [hpt_pkg::PW-1:0] m [hpt_pkg::NUM_REGS]);
        for (int i = 0; i < hpt_pkg::NUM_REGS; i++)
            cfg_write(i, m[i]);
        cfg_write($urandom_range(hpt_pkg::NUM_REGS, 2 * hpt_pkg::NUM_REGS - 1),
                  {$urandom, $urandom});
        cfg_release();
    endtask

    function logic [31:0] rand_coord();
        case ($urandom_range(4))
            0, 1: return $urandom;
            2: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            3: return $urandom_range(0, 32'h0000_0400) - 32'h0000_0200;
            default:
                case ($urandom_range(4))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return Q_ONE;
                    3: return Q_NEG_ONE;
                    default: return '0;
                endcase
        endcase
    endfunction

    function logic [31:0] small_coef();
        return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endfunction

    function void build_matrix(int kind, output logic [hpt_pkg::PW-1:0] m [hpt_pkg::NUM_REGS]);
        for (int i = 0; i < hpt_pkg::NUM_REGS; i++)
            m[i] = hpt_pkg::CFG_RESET[i];
        case (kind)
            1:
                for (int i = 0; i < hpt_pkg::NUM_REGS; i++)
                    m[i] = {$urandom, $urandom};
            2:
                for (int i = 0; i < hpt_pkg::NUM_REGS; i++)
                    m[i] = {small_coef(), small_coef()};
            3:
            begin
                for (int i = 0; i < REG_R3C01; i++)
                    m[i] = {small_coef(), small_coef()};
                m[REG_R3C01] = '0;
                m[REG_R3C23] = {32'h0, ($urandom_range(1) ? Q_ONE : small_coef())};
            end
            4:
                for (int i = 0; i < hpt_pkg::NUM_REGS; i++)
                    m[i] = $urandom_range(1) ? {Q_MAX, Q_MIN} : {Q_MIN, Q_MAX};
            5:
            begin
                for (int i = 0; i < REG_R3C01; i++)
                    m[i] = {small_coef(), small_coef()};
                m[REG_R3C01] = {32'h0000_0001 << $urandom_range(3), 32'h0000_0001};
                m[REG_R3C23] = '0;
            end
            default: ;
        endcase
    endfunction

    initial
    begin
        logic [hpt_pkg::PW-1:0] m [hpt_pkg::NUM_REGS];
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_point('0, '0, '0);
        send_point(Q_MAX, Q_MAX, Q_MAX);
        send_point(Q_MIN, Q_MIN, Q_MIN);
        send_point(Q_ONE, Q_NEG_ONE, Q_MAX);
        send_point(32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001);
        drain();

        build_matrix(0, m);
        m[REG_R3C01] = '0;
        m[REG_R3C23] = '0;
        load_matrix(m);
        send_point(Q_ONE, Q_MAX, Q_MIN);
        send_point('0, '0, '0);
        drain();

        m[REG_R3C23] = {32'h0000_0001, 32'h0};
        load_matrix(m);
        send_point(Q_MAX, Q_MIN, Q_ONE);
        send_point(32'h0000_0001, 32'hffff_ffff, '0);
        send_point(Q_MIN, Q_MAX, Q_NEG_ONE);
        drain();

        build_matrix(4, m);
        load_matrix(m);
        send_point(Q_MAX, Q_MAX, Q_MAX);
        send_point(Q_MIN, Q_MAX, Q_MIN);
        send_point(Q_MIN, Q_MIN, Q_MIN);
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 82 : 0;
            recv_stall_pct = (phase == 0) ? 82 : (phase == 1) ? 7 : 0;
            for (int s = 0; s < SETTINGS_PER_PHASE; s++)
            begin
                build_matrix((s + phase) % 6, m);
                load_matrix(m);
                for (int n = 0; n < ITEMS_PER_SETTING; n++)
                    send_point(rand_coord(), rand_coord(), rand_coord());
                drain();
            end
        end

        if (sb.mismatches == 0)
            $display("homogeneous_point_transform regression: pass");
        else
            $display("homogeneous_point_transform regression: fail");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/hpt_pkg.sv
rtl/hpt_div_stage.sv
rtl/homogeneous_point_transform.sv
sim/tb.sv
